// ===== design/tiff_pixel_to_float_rgba_macros.svh =====
// Assertion macros shared by the checker of the pixel-to-float block.
// Depends on nothing; included by the checker file.
`ifndef TIFF_PIXEL_TO_FLOAT_RGBA_MACROS_SVH
`define TIFF_PIXEL_TO_FLOAT_RGBA_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/tpf_pkg.sv =====
// Shared types, format codes and conversion helpers for the pixel-to-float block.
// Depends on nothing.
package tpf_pkg;

  typedef enum logic [1:0] {
    FMT_U8     = 2'd0,
    FMT_U16    = 2'd1,
    FMT_HALF   = 2'd2,
    FMT_SINGLE = 2'd3
  } fmt_t;

  localparam int unsigned NumLanes = 3;
  localparam int unsigned CfgWidth = 3;
  localparam logic [0:0] RegFormat = 1'b0;
  localparam logic [0:0] RegSpp    = 1'b1;
  localparam logic [CfgWidth-1:0] SppGray = 3'd1;
  localparam logic [CfgWidth-1:0] SppReset = 3'd3;

  // Significands of the single constants 1/255 and 1/65535 (hidden bit set).
  localparam logic [23:0] MantU8  = 24'h808081;
  localparam logic [23:0] MantU16 = 24'h800080;
  // Biased exponents of those constants.
  localparam logic [7:0] ExpU8  = 8'd119;
  localparam logic [7:0] ExpU16 = 8'd111;

  // Per-lane information handed from the first stage to the second.
  typedef struct packed {
    logic        is_int;
    logic        zero;
    logic [39:0] prod;
    logic [7:0]  exp_base;
    logic [31:0] direct;
  } lane_mid_t;

  // Position of the highest set bit of a 40-bit word.
  function automatic logic [5:0] msb_pos(input logic [39:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 40; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Exact widening of a half word.
  function automatic logic [31:0] half_widen(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [22:0] f;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    f = 23'({m, 13'd0} << (4'd10 - p));
    if (e == 5'h1f) return {h[15], 8'hff, m, 13'd0};
    if (e != 5'd0) return {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
    if (m == 10'd0) return {h[15], 31'd0};
    return {h[15], 8'({4'd0, p} + 8'd103), f};
  endfunction

endpackage

// ===== design/tpf_lane.sv =====
// One conversion lane: multiplies integer samples, widens halves, passes singles.
// Depends on tpf_pkg.
module tpf_lane
  import tpf_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  fmt_t        fmt,
  input  logic [31:0] sample,
  output logic [31:0] result
);

  lane_mid_t mid_r, mid_nxt;
  logic [15:0] ival;
  logic [5:0]  pos;
  logic [39:0] norm;
  logic [23:0] mant;
  logic        rnd;
  logic [24:0] mant_rnd;
  logic [7:0]  exp_out;

  // First stage: integer times constant significand, or the final word.
  always_comb begin
    ival = (fmt == FMT_U8) ? {8'd0, sample[7:0]} : sample[15:0];
    mid_nxt.is_int = (fmt == FMT_U8) || (fmt == FMT_U16);
    mid_nxt.zero = (ival == 16'd0);
    mid_nxt.prod = {24'd0, ival} * {16'd0, ((fmt == FMT_U8) ? MantU8 : MantU16)};
    mid_nxt.exp_base = (fmt == FMT_U8) ? ExpU8 : ExpU16;
    case (fmt)
      FMT_HALF:   mid_nxt.direct = half_widen(sample[15:0]);
      FMT_SINGLE: mid_nxt.direct = sample;
      default:    mid_nxt.direct = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) mid_r <= mid_nxt;
  end

  // Second stage: normalize the product and round to nearest even.
  always_comb begin
    pos  = msb_pos(mid_r.prod);
    norm = mid_r.prod << (6'd39 - pos);
    mant = norm[39:16];
    rnd  = norm[15] && ((norm[14:0] != 15'd0) || norm[16]);
    mant_rnd = {1'b0, mant} + {24'd0, rnd};
    // Product scale: value = prod * 2^(exp_base-127-23); msb at pos.
    exp_out = 8'(mid_r.exp_base + 8'(pos) - 8'd23 + {7'd0, mant_rnd[24]});
    if (!mid_r.is_int) result = mid_r.direct;
    else if (mid_r.zero) result = 32'd0;
    else if (mant_rnd[24]) result = {1'b0, exp_out, 23'd0};
    else result = {1'b0, exp_out, mant_rnd[22:0]};
  end

endmodule

// ===== design/tiff_pixel_to_float_rgba.sv =====
// Top level of the pixel-to-float block: three conversion lanes and a merging stage.
// Depends on tpf_pkg and tpf_lane.
// One pixel word is accepted every cycle while in_stall is low; the depth is set by
// the lane multiplier stage followed by the normalize and round stage, which feeds
// the output register. Words keep their order, and a result waits in the output
// register; the pipeline keeps accepting while that register can move forward.
module tiff_pixel_to_float_rgba
  import tpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_first_sample,
  input  logic [31:0]         in_second_sample,
  input  logic [31:0]         in_third_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_red_value,
  output logic [31:0]         out_green_value,
  output logic [31:0]         out_blue_value,
  output logic [0:0]          out_fourth_value
);

  fmt_t                fmt_r;
  logic [CfgWidth-1:0] spp_r;
  logic                v1_r, v2_r, gray1_r;
  logic                adv2, adv1;
  logic [31:0]         res [NumLanes];
  logic [31:0]         smp [NumLanes];
  logic [31:0]         red_r, green_r, blue_r;

  assign smp[0] = in_first_sample;
  assign smp[1] = in_second_sample;
  assign smp[2] = in_third_sample;

  // Pipeline advance: output slot moves when empty or taken.
  assign adv2 = !v2_r || !out_stall;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_U8;
      spp_r <= SppReset;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == RegFormat) fmt_r <= fmt_t'(cfg_data[1:0]);
      if (cfg_we && cfg_index == RegSpp) spp_r <= cfg_data;
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) gray1_r <= (spp_r == SppGray);
  end

  // Lanes, one per color sample.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    tpf_lane u_lane (
      .clk    (clk),
      .en     (adv1),
      .fmt    (fmt_r),
      .sample (smp[g]),
      .result (res[g])
    );
  end

  // Merge: gray pixels copy the first lane to all colors.
  always_ff @(posedge clk) begin
    if (adv2) begin
      red_r   <= res[0];
      green_r <= gray1_r ? res[0] : res[1];
      blue_r  <= gray1_r ? res[0] : res[2];
    end
  end

  assign out_valid        = v2_r;
  assign out_red_value    = red_r;
  assign out_green_value  = green_r;
  assign out_blue_value   = blue_r;
  assign out_fourth_value = 1'b0;

endmodule

// ===== design/tpf_checker.sv =====
// Port-level checker for the pixel-to-float block, bound to the top level.
// Depends on tiff_pixel_to_float_rgba_macros.svh.
`include "tiff_pixel_to_float_rgba_macros.svh"
module tpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_red_value,
  input logic [0:0]  out_fourth_value
);

  // A stalled result word holds its value.
  `TPF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, $stable(out_red_value), "held word changed")
  // The fourth channel, a single bit, is zero whenever a word is valid.
  `TPF_ASSERT_IMP(a_fourth, clk, rst_n, out_valid, out_fourth_value == 1'b0, "fourth not zero")
  // Input stalls only when the output is full and stalled.
  `TPF_ASSERT_IMP(a_stall, clk, rst_n, in_stall, out_valid && out_stall, "needless stall")
  // An accepted word reaches the output when the output is free.
  `TPF_ASSERT_IMP(a_lat, clk, rst_n, in_valid && !in_stall ##1 !out_stall ##1 !out_stall, out_valid, "word lost")

endmodule

bind tiff_pixel_to_float_rgba tpf_checker u_tpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_red_value    (out_red_value),
  .out_fourth_value (out_fourth_value)
);
